// ===== rtl/core/mmh_pkg.sv =====
// Package for the streaming MurmurHash64A unit: constants, queue entry and sequencer types.
// Has no dependencies. Every other file but mmh_checker refers to it by scoped names.
`default_nettype none

package mmh_pkg;

	// Mix constant, shift and seed after reset
	localparam logic [63:0] MIX_M      = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_R      = 47;
	localparam logic [63:0] SEED_RESET = 64'hdeadbeefdeadbeef;

	// Word classes, set by the front when it takes a request
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_FULL = 2'd1,
		KIND_PART = 2'd2
	} kind_t;

	// One request as it travels from the front to the back
	typedef struct packed {
		logic [63:0] word;
		logic [31:0] len;
		kind_t       kind;
		logic        first;
		logic        last;
		logic        err;
	} entry_t;

	// Back sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LEN,
		BK_ABS,
		BK_K1,
		BK_K2,
		BK_HM,
		BK_FIN,
		BK_EMIT
	} back_state_t;

	// Multiplier steps, one partial product each
	typedef enum logic [1:0] {
		MS_LL,
		MS_LH,
		MS_HL
	} mul_step_t;

	// x xor (x >> 47)
	function automatic logic [63:0] mix_shift(input logic [63:0] x);
		mix_shift = x ^ (x >> MIX_R);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mmh_front.sv =====
// Front of the hash unit: takes requests, tracks message framing and classifies each word.
// Depends on mmh_pkg for the entry and word class types.
`default_nettype none

module mmh_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [63:0]    data_word,
	input  wire logic [3:0]     valid_bytes,
	input  wire logic           first,
	input  wire logic           last,
	input  wire logic [31:0]    total_length,
	input  wire logic           q_space,
	output logic                push,
	output mmh_pkg::entry_t     push_ent
);

	logic              in_msg_q;
	logic              err_q;
	logic [3:0]        n_eff;
	logic [63:0]       word_m;
	mmh_pkg::kind_t    kind;
	logic              keep;
	logic              err_eff;
	logic              accept;

	assign in_ready = q_space;
	assign accept   = in_valid && in_ready;
	assign keep     = first || in_msg_q;

	// Clamp the byte count and keep only the meaningful bytes
	always_comb begin
		n_eff  = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
		word_m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n_eff) begin
				word_m[8*i +: 8] = data_word[8*i +: 8];
			end
		end
	end

	// Classify the word
	always_comb begin
		if (n_eff == 4'd8) begin
			kind = mmh_pkg::KIND_FULL;
		end else if (n_eff == 4'd0) begin
			kind = mmh_pkg::KIND_NONE;
		end else begin
			kind = mmh_pkg::KIND_PART;
		end
		err_eff = (first ? 1'b0 : err_q) || ((kind == mmh_pkg::KIND_PART) && !last);
	end

	// Drop requests that fall outside a message
	assign push = accept && keep;

	always_comb begin
		push_ent.word  = word_m;
		push_ent.len   = total_length;
		push_ent.kind  = kind;
		push_ent.first = first;
		push_ent.last  = last;
		push_ent.err   = err_eff;
	end

	// Track message framing and the latched format error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (push) begin
			in_msg_q <= !last;
			err_q    <= last ? 1'b0 : err_eff;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mmh_queue.sv =====
// Short request queue between front and back, built from flip-flops.
// Depends on mmh_pkg for the entry type.
`default_nettype none

module mmh_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mmh_pkg::entry_t push_ent,
	output logic                 space,
	input  wire logic            pop,
	output mmh_pkg::entry_t      pop_ent,
	output logic                 avail
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mmh_pkg::entry_t  ent_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign space   = (cnt_q != CW'(DEPTH));
	assign avail   = (cnt_q != '0);
	assign do_push = push && space;
	assign do_pop  = pop && avail;
	assign pop_ent = ent_q[rd_ptr_q];

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mmh_mul.sv =====
// Multiplier by the mix constant, modulo 2^64, on one 32x32 multiplier.
// Depends on mmh_pkg for the constant and the step type.
`default_nettype none

module mmh_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	output logic             done,
	output logic [63:0]      prod
);

	logic [63:0]         a_q;
	logic [63:0]         prod_q;
	mmh_pkg::mul_step_t  step_q;
	mmh_pkg::mul_step_t  step_d;
	logic                busy_q;
	logic                busy_d;
	logic                done_q;
	logic                done_d;
	logic [31:0]         op_x;
	logic [31:0]         op_y;
	logic [63:0]         mult;

	assign done = done_q;
	assign prod = prod_q;

	// Select the partial product for this step
	always_comb begin
		case (step_q)
			mmh_pkg::MS_LL: begin
				op_x = a_q[31:0];
				op_y = mmh_pkg::MIX_M[31:0];
			end
			mmh_pkg::MS_LH: begin
				op_x = a_q[31:0];
				op_y = mmh_pkg::MIX_M[63:32];
			end
			default: begin
				op_x = a_q[63:32];
				op_y = mmh_pkg::MIX_M[31:0];
			end
		endcase
		mult = 64'(op_x) * 64'(op_y);
	end

	// Accumulate partial products
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end else if (busy_q) begin
			if (step_q == mmh_pkg::MS_LL) begin
				prod_q <= mult;
			end else begin
				prod_q[63:32] <= prod_q[63:32] + mult[31:0];
			end
		end
	end

	// Next step and completion pulse
	always_comb begin
		step_d = step_q;
		busy_d = busy_q;
		done_d = 1'b0;
		if (start) begin
			step_d = mmh_pkg::MS_LL;
			busy_d = 1'b1;
		end else if (busy_q) begin
			case (step_q)
				mmh_pkg::MS_LL: begin
					step_d = mmh_pkg::MS_LH;
				end
				mmh_pkg::MS_LH: begin
					step_d = mmh_pkg::MS_HL;
				end
				default: begin
					step_d = mmh_pkg::MS_LL;
					busy_d = 1'b0;
					done_d = 1'b1;
				end
			endcase
		end
	end

	// Step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mmh_pkg::MS_LL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= step_d;
			busy_q <= busy_d;
			done_q <= done_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mmh_back.sv =====
// Back of the hash unit: sequences the accumulator recurrence and holds the result register.
// Depends on mmh_pkg and instantiates mmh_mul.
`default_nettype none

module mmh_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [63:0]     seed,
	input  wire logic            q_avail,
	input  wire mmh_pkg::entry_t q_ent,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [63:0]          hash,
	output logic                 format_error
);

	mmh_pkg::back_state_t  state_q;
	mmh_pkg::back_state_t  state_d;
	mmh_pkg::entry_t       ent_q;
	logic [63:0]           h_q;
	logic [63:0]           h_d;
	logic                  h_load;
	logic [63:0]           res_q;
	logic                  res_load;
	logic                  out_load;
	logic                  out_valid_q;
	logic [63:0]           hash_q;
	logic                  err_q;
	logic                  mul_start;
	logic [63:0]           mul_a;
	logic                  mul_done;
	logic [63:0]           mul_prod;

	mmh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mul_start = 1'b0;
		mul_a     = h_q;
		h_load    = 1'b0;
		h_d       = h_q;
		res_load  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			mmh_pkg::BK_IDLE: begin
				if (q_avail) begin
					pop = 1'b1;
					if (q_ent.first) begin
						mul_start = 1'b1;
						mul_a     = {32'd0, q_ent.len};
						state_d   = mmh_pkg::BK_LEN;
					end else begin
						state_d   = mmh_pkg::BK_ABS;
					end
				end
			end
			mmh_pkg::BK_LEN: begin
				if (mul_done) begin
					h_d     = seed ^ mul_prod;
					h_load  = 1'b1;
					state_d = mmh_pkg::BK_ABS;
				end
			end
			mmh_pkg::BK_ABS: begin
				case (ent_q.kind)
					mmh_pkg::KIND_FULL: begin
						mul_start = 1'b1;
						mul_a     = ent_q.word;
						state_d   = mmh_pkg::BK_K1;
					end
					mmh_pkg::KIND_PART: begin
						h_d       = h_q ^ ent_q.word;
						h_load    = 1'b1;
						mul_start = 1'b1;
						mul_a     = h_d;
						state_d   = mmh_pkg::BK_HM;
					end
					default: begin
						if (ent_q.last) begin
							mul_start = 1'b1;
							mul_a     = mmh_pkg::mix_shift(h_q);
							state_d   = mmh_pkg::BK_FIN;
						end else begin
							state_d   = mmh_pkg::BK_IDLE;
						end
					end
				endcase
			end
			mmh_pkg::BK_K1: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mmh_pkg::mix_shift(mul_prod);
					state_d   = mmh_pkg::BK_K2;
				end
			end
			mmh_pkg::BK_K2: begin
				if (mul_done) begin
					h_d       = h_q ^ mul_prod;
					h_load    = 1'b1;
					mul_start = 1'b1;
					mul_a     = h_d;
					state_d   = mmh_pkg::BK_HM;
				end
			end
			mmh_pkg::BK_HM: begin
				if (mul_done) begin
					h_d    = mul_prod;
					h_load = 1'b1;
					if (ent_q.last) begin
						mul_start = 1'b1;
						mul_a     = mmh_pkg::mix_shift(mul_prod);
						state_d   = mmh_pkg::BK_FIN;
					end else begin
						state_d   = mmh_pkg::BK_IDLE;
					end
				end
			end
			mmh_pkg::BK_FIN: begin
				if (mul_done) begin
					res_load = 1'b1;
					state_d  = mmh_pkg::BK_EMIT;
				end
			end
			mmh_pkg::BK_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = mmh_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mmh_pkg::BK_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmh_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_ent;
		end
		if (h_load) begin
			h_q <= h_d;
		end
		if (res_load) begin
			res_q <= mmh_pkg::mix_shift(mul_prod);
		end
		if (out_load) begin
			hash_q <= res_q;
			err_q  <= ent_q.err;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hash         = hash_q;
	assign format_error = err_q;

endmodule

`default_nettype wire

// ===== rtl/core/murmur64a_stream_hash_unit.sv =====
// Streaming MurmurHash64A unit: seed register, front, request queue and back.
// Depends on mmh_pkg and instantiates mmh_front, mmh_queue and mmh_back.
`default_nettype none

// Hashes messages that arrive as little-endian 64-bit words and returns one 64-bit
// MurmurHash64A per message, after the request marked last. All multiplies by the mix
// constant share one 32x32 multiplier. After taking a request, the back multiplies a
// full word, mixes and multiplies it again, folds it into the accumulator and multiplies
// that; a partial word is folded in and the accumulator multiplied; an empty word adds
// no product. The first word of a message adds the length mix, the last the finish (one
// product and the hand-off to the result register). The front takes a request in any
// cycle the queue (QUEUE_DEPTH entries) has room, and the result register lets the back
// start the next message while a hash waits to be taken. The user must write the seed
// through the configuration port only while the unit is idle; the unit does not enforce
// this. The seed resets to 0xdeadbeefdeadbeef. A short word before the last one sets
// format_error on that message's result.
module murmur64a_stream_hash_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        first,
	input  wire logic        last,
	input  wire logic [31:0] total_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      hash,
	output logic             format_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_data
);

	logic [63:0]      seed_q;
	logic             q_space;
	logic             push;
	mmh_pkg::entry_t  push_ent;
	logic             pop;
	mmh_pkg::entry_t  pop_ent;
	logic             q_avail;

	// Seed register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= mmh_pkg::SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	mmh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.first        (first),
		.last         (last),
		.total_length (total_length),
		.q_space      (q_space),
		.push         (push),
		.push_ent     (push_ent)
	);

	mmh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.space    (q_space),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.avail    (q_avail)
	);

	mmh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed         (seed_q),
		.q_avail      (q_avail),
		.q_ent        (pop_ent),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash         (hash),
		.format_error (format_error)
	);

endmodule

`default_nettype wire

// ===== rtl/core/mmh_checker.sv =====
// Port-level checks for the streaming hash unit, bound to its top level.
// Sees the top-level ports only; no package dependency.
`default_nettype none

module mmh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] hash,
	input wire logic        format_error
);

	logic [7:0] pend_q;
	logic       seen_q;
	logic       inc;
	logic       dec;

	assign inc = in_valid && in_ready && last && (pend_q != 8'hff);
	assign dec = out_valid && out_ready && (pend_q != 8'd0);

	// Count last requests not yet answered, and note any accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'd0;
			seen_q <= 1'b0;
		end else begin
			if (inc && !dec) begin
				pend_q <= pend_q + 8'd1;
			end else if (dec && !inc) begin
				pend_q <= pend_q - 8'd1;
			end
			if (in_valid && in_ready) begin
				seen_q <= 1'b1;
			end
		end
	end

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash) && $stable(format_error))
		else $error("result changed while stalled");

	// No result without a last request behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result without a pending last request");

	// Input backpressure only after requests have been taken
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> seen_q)
		else $error("input stalled with nothing accepted");

endmodule

bind murmur64a_stream_hash_unit mmh_checker u_mmh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.last         (last),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hash         (hash),
	.format_error (format_error)
);

`default_nettype wire

// ===== tb/murmur64a_hash_checker.sv =====
// Hash checker for the streaming MurmurHash64A unit: watches the seed, request and result
// channels, predicts each message hash and compares it with what the unit delivers.
// Depends on mmh_pkg for the mix constant and the seed value after reset.
`timescale 1ns / 1ps

module murmur64a_hash_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        first,
	input  wire logic        last,
	input  wire logic [31:0] total_length,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] hash,
	input  wire logic        format_error,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [63:0] cfg_data,
	output int               mismatch_count,
	output int               hashes_owed
);

	localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
	localparam logic [3:0] NO_BYTES        = 4'd0;

	typedef struct packed {
		logic [63:0] hash;
		logic        format_error;
	} digest_t;

	// Hashes of finished messages, oldest first
	digest_t digest_q[$];

	// Predicted unit state
	logic [63:0] seed_reg;
	logic [63:0] running_hash;
	logic        msg_open;
	logic        short_seen;

	// Scramble one full message word
	function automatic logic [63:0] scramble_word(input logic [63:0] k);
		logic [63:0] t;
		t = k * mmh_pkg::MIX_M;
		t = t ^ (t >> 47);
		return t * mmh_pkg::MIX_M;
	endfunction

	// Final avalanche of the accumulator
	function automatic logic [63:0] avalanche(input logic [63:0] h);
		logic [63:0] t;
		t = h ^ (h >> 47);
		t = t * mmh_pkg::MIX_M;
		return t ^ (t >> 47);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		digest_t     want;
		digest_t     fresh;
		logic [63:0] acc_n;
		logic [63:0] tail_mask;
		logic        open_n;
		logic        short_n;
		logic [3:0]  nbytes;
		int          bad;
		if (!arst_n) begin
			seed_reg       <= mmh_pkg::SEED_RESET;
			running_hash   <= '0;
			msg_open       <= 1'b0;
			short_seen     <= 1'b0;
			mismatch_count <= 0;
			hashes_owed    <= 0;
			digest_q.delete();
		end else begin
			bad     = 0;
			acc_n   = running_hash;
			open_n  = msg_open;
			short_n = short_seen;

			// Take the seed on a configuration request
			if (cfg_valid && cfg_ready)
				seed_reg <= cfg_data;

			// Compare a delivered hash with the oldest pending one
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$display("%0t: hash %h format_error %b with no message pending",
						$time, hash, format_error);
					bad++;
				end else begin
					want = digest_q.pop_front();
					if (hash !== want.hash) begin
						$display("%0t: hash expected %h actual %h", $time, want.hash, hash);
						bad++;
					end
					if (format_error !== want.format_error) begin
						$display("%0t: format_error expected %b actual %b",
							$time, want.format_error, format_error);
						bad++;
					end
				end
			end

			// Absorb an accepted request
			if (in_valid && in_ready) begin
				if (first) begin
					acc_n   = seed_reg ^ (64'(total_length) * mmh_pkg::MIX_M);
					open_n  = 1'b1;
					short_n = 1'b0;
				end
				if (open_n) begin
					nbytes = (valid_bytes > FULL_WORD_BYTES) ? FULL_WORD_BYTES : valid_bytes;
					if (nbytes == FULL_WORD_BYTES) begin
						acc_n = (acc_n ^ scramble_word(data_word)) * mmh_pkg::MIX_M;
					end else if (nbytes != NO_BYTES) begin
						tail_mask = ~({64{1'b1}} << {nbytes, 3'b000});
						acc_n     = (acc_n ^ (data_word & tail_mask)) * mmh_pkg::MIX_M;
						if (!last)
							short_n = 1'b1;
					end
					if (last) begin
						fresh.hash         = avalanche(acc_n);
						fresh.format_error = short_n;
						digest_q.insert(digest_q.size(), fresh);
						open_n  = 1'b0;
						short_n = 1'b0;
					end
				end
			end

			running_hash   <= acc_n;
			msg_open       <= open_n;
			short_seen     <= short_n;
			mismatch_count <= mismatch_count + bad;
			hashes_owed    <= digest_q.size();
		end
	end

endmodule

// ===== tb/murmur64a_stream_hash_unit_test.sv =====
// Top of the testbench for murmur64a_stream_hash_unit: clock, reset, message stimulus,
// result back-pressure and the verdict. Depends on mmh_pkg and murmur64a_hash_checker.
`timescale 1ns / 1ps

module murmur64a_stream_hash_unit_test;

	localparam int          SETTLE_CYCLES  = 200;
	localparam int          PHASE_WORDS    = 300;
	localparam logic [3:0]  FULL_WORD      = 4'd8;
	localparam logic [3:0]  EMPTY_WORD     = 4'd0;
	localparam logic [63:0] ALL_ONES       = {64{1'b1}};

	// Receiver behavior for one stretch of cycles
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_CHOPPY,
		RX_BLOCKED
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] data_word = '0;
	logic [3:0]  valid_bytes = '0;
	logic        first = 1'b0;
	logic        last = 1'b0;
	logic [31:0] total_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] hash;
	logic        format_error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [63:0] cfg_data = '0;

	int mismatch_count;
	int hashes_owed;

	int       words_fed = 0;
	int       strays_fed = 0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	murmur64a_stream_hash_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.first        (first),
		.last         (last),
		.total_length (total_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash         (hash),
		.format_error (format_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	murmur64a_hash_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.first          (first),
		.last           (last),
		.total_length   (total_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hash           (hash),
		.format_error   (format_error),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.hashes_owed    (hashes_owed)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stall the result channel in stretches: open, choppy or blocked
	always @(posedge clk) begin
		if (rx_left == 0) begin
			case ($urandom_range(0, 3))
				0, 1: rx_mode <= RX_OPEN;
				2: rx_mode <= RX_CHOPPY;
				default: rx_mode <= RX_BLOCKED;
			endcase
			rx_left <= $urandom_range(1, 40);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= 1'b0;
		endcase
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Send one request; idle between bursts, hold valid until accepted
	task automatic push_word(input logic [63:0] w, input logic [3:0] nb, input logic f,
			input logic l, input logic [31:0] len);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid     <= 1'b1;
		data_word    <= w;
		valid_bytes  <= nb;
		first        <= f;
		last         <= l;
		total_length <= len;
		do @(posedge clk); while (!in_ready);
		words_fed++;
	endtask

	// Hold off the sender until every pending hash has come, then let the back settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (hashes_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the seed; only called while the unit is idle
	task automatic write_seed(input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Send one random message, mostly well formed, sometimes broken
	task automatic send_message();
		int unsigned nbytes;
		int unsigned words;
		int unsigned tail;
		int unsigned flaw;
		int unsigned pick;
		logic [31:0] len;
		logic [3:0]  nb;
		logic        last_on_full;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			nbytes = $urandom_range(0, 24);
		else if (pick < 18)
			nbytes = $urandom_range(25, 80);
		else
			nbytes = $urandom_range(81, 200);
		len   = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(nbytes);
		words = nbytes / 8;
		tail  = nbytes % 8;
		flaw  = $urandom_range(0, 9);

		// Abandon: open a message and drop it before its last word
		if (flaw == 0) begin
			push_word(rand_word(), 4'($urandom_range(0, 8)), 1'b1, 1'b0, len);
			repeat ($urandom_range(0, 3))
				push_word(rand_word(), FULL_WORD, 1'b0, 1'b0, len);
			return;
		end

		last_on_full = (tail == 0) && (words > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < words; i++) begin
			nb = (flaw == 3 && $urandom_range(0, 1) == 1) ? 4'($urandom_range(9, 15)) : FULL_WORD;
			push_word(rand_word(), nb, i == 0, last_on_full && i == words - 1, len);
			// Slip in a short word before the end
			if (flaw == 1 && i == 0 && !(last_on_full && words == 1))
				push_word(rand_word(), 4'($urandom_range(1, 7)), 1'b0, 1'b0, len);
			// Slip in an empty word before the end
			if (flaw == 2 && $urandom_range(0, 2) == 0 && !(last_on_full && i == words - 1))
				push_word(rand_word(), EMPTY_WORD, 1'b0, 1'b0, len);
		end
		if (!last_on_full) begin
			nb = (flaw == 3 && tail == 0 && $urandom_range(0, 1) == 1)
				? 4'($urandom_range(9, 15)) : 4'(tail);
			push_word(rand_word(), nb, words == 0, 1'b1, len);
		end
	endtask

	initial begin
		logic [63:0] phase_seed;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages under the seed from reset
		push_word(rand_word(), 4'd3, 1'b0, 1'b1, 32'd5);            // stray, no message open
		push_word('0, EMPTY_WORD, 1'b1, 1'b1, '0);                   // empty message
		push_word(ALL_ONES, FULL_WORD, 1'b1, 1'b1, 32'hffff_ffff);   // one word, first and last
		push_word(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'd24);
		push_word(rand_word(), 4'd15, 1'b0, 1'b0, 32'd24);           // oversized count
		push_word(rand_word(), 4'd9, 1'b0, 1'b1, 32'd24);
		push_word(ALL_ONES, FULL_WORD, 1'b1, 1'b0, 32'd15);
		push_word(ALL_ONES, 4'd7, 1'b0, 1'b1, 32'd15);               // seven-byte tail
		push_word(ALL_ONES, 4'd1, 1'b1, 1'b1, 32'd1);                // one-byte message
		push_word(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'd16);
		push_word(rand_word(), 4'd5, 1'b0, 1'b0, 32'd16);            // short word before last
		push_word(rand_word(), EMPTY_WORD, 1'b0, 1'b1, 32'd16);
		push_word(rand_word(), EMPTY_WORD, 1'b1, 1'b0, 32'd8);       // empty word before last
		push_word(rand_word(), FULL_WORD, 1'b0, 1'b0, 32'd8);
		push_word(rand_word(), EMPTY_WORD, 1'b0, 1'b1, 32'd8);
		push_word(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'd40);       // dropped by the next first
		push_word(rand_word(), FULL_WORD, 1'b1, 1'b0, 32'd9);
		push_word(rand_word(), 4'd1, 1'b0, 1'b1, 32'd9);
		push_word(rand_word(), FULL_WORD, 1'b1, 1'b1, 32'h8000_0001); // length does not match
		push_word(ALL_ONES, 4'hf, 1'b1, 1'b1, '0);
		push_word('0, FULL_WORD, 1'b1, 1'b1, '0);

		// Random phases, each under its own seed
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: phase_seed = '0;
				1: phase_seed = ALL_ONES;
				4: phase_seed = mmh_pkg::SEED_RESET;
				default: phase_seed = rand_word();
			endcase
			wait_drained();
			write_seed(phase_seed);
			while (words_fed - strays_fed < 25 + (phase + 1) * PHASE_WORDS) begin
				if ($urandom_range(0, 19) == 0) begin
					push_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0,
						1'($urandom_range(0, 1)), $urandom);
					strays_fed++;
				end else begin
					send_message();
				end
			end
		end

		wait_drained();
		if (mismatch_count == 0 && hashes_owed == 0) begin
			$display("[murmur64a_stream_hash_unit] OK");
		end else begin
			$display("[murmur64a_stream_hash_unit] ERROR");
		end
		$finish;
	end

	// End a hung run
	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d hashes pending", $time, hashes_owed);
		$display("[murmur64a_stream_hash_unit] ERROR");
		$finish;
	end

endmodule
